/* sv/shbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package shbm_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int LENGTH_BITS_DEF = 16;

    localparam int SYM_W      = 8;
    localparam int POS_W      = 5;
    localparam int SEQ_W      = 2;
    localparam int CNT_W      = 6;
    localparam int MASK_W     = 3;
    localparam int NUM_SEQ    = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int IN_PAD_W   = IN_DATA_W - SYM_W - POS_W - SEQ_W;
    localparam int OUT_PAD_W  = OUT_DATA_W - SEQ_W - CNT_W - 2 - MASK_W;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_STREAM = 1'b1;

    localparam logic [SEQ_W-1:0] SEQ_FIRST = 2'd0;
    localparam logic [SEQ_W-1:0] SEQ_FINAL = 2'd2;
    localparam logic [SEQ_W-1:0] SEQ_NONE  = 2'd3;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LEN_DIFF = 2'd1,
        STATUS_SHORT    = 2'd2
    } status_t;

    typedef struct packed {
        logic             mode;
        logic [SYM_W-1:0] symbol;
        logic [POS_W-1:0] position;
        logic [SEQ_W-1:0] seq_idx;
        logic             last;
    } item_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  done_sequence;
        logic [CNT_W-1:0]  best_matches;
        status_t           status;
        logic              final_report;
        logic [MASK_W-1:0] best_mask;
    } result_t;

endpackage

`default_nettype wire

/* sv/sliding_hamming_best_match.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window Hamming best match. Load the pattern with mode 0 transactions
// (one symbol per pattern_position), set the window length on the cfg channel
// (0 reads as 1, values above PATTERN_MAX as PATTERN_MAX), then stream the three
// sequences with mode 1. Every sequence symbol shifts a window of the last
// PATTERN_MAX symbols; all pattern positions are compared in parallel and
// counted, and the highest count over full windows is kept. The transaction
// carrying tlast produces one result: that sequence's best count and sticky
// status; after sequence 2 the result also flags final_report and the mask of
// sequences tying a nonzero maximum (empty if status is not ok). The block takes
// one transaction per cycle while the result slot does not stall it; a result
// reaches the master side through the input register and the result register
// around the compare and popcount logic. Symbols with sequence index 3 are dropped.
// Only a tlast transaction waits for a stalled result slot; others keep flowing.
// Write cfg only while no transaction is in flight.

module sliding_hamming_best_match #(
    parameter int PATTERN_MAX = shbm_pkg::PATTERN_MAX_DEF,
    parameter int LENGTH_BITS = shbm_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [shbm_pkg::CNT_W-1:0]      cfg_data,   // pattern_length

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] symbol, [12:8] pattern_position, [14:13] sequence_index, [15] zero
    input  wire logic [shbm_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                            s_tuser,    // mode
    input  wire logic                            s_tlast,    // last_symbol

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [1:0] done_sequence, [7:2] best_matches, [9:8] status,
    // [12:10] best_mask, [15:13] zero
    output logic [shbm_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tuser     // final_report
);
    import shbm_pkg::*;

    logic             in_valid_reg;
    item_t            item_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    logic [CNT_W-1:0] plen_reg, plen_next;

    logic             is_stream;
    logic             emits;
    logic             advance;
    logic             load_en;
    logic             step;
    logic [CNT_W-1:0] match_cnt;
    result_t          result;

    // Configuration: always ready, clamp the window length on the way in.
    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_data == '0) begin
            plen_next = CNT_W'(1);
        end else if (int'(cfg_data) > PATTERN_MAX) begin
            plen_next = CNT_W'(PATTERN_MAX);
        end else begin
            plen_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= CNT_W'(1);
        end else if (cfg_valid) begin
            plen_reg <= plen_next;
        end
    end

    // Process the held transaction unless it must produce a result and the
    // result register is still full.
    assign is_stream = (item_reg.mode == MODE_STREAM) && (item_reg.seq_idx != SEQ_NONE);
    assign emits     = is_stream && item_reg.last;
    assign advance   = in_valid_reg && (!emits || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign load_en   = advance && (item_reg.mode == MODE_LOAD);
    assign step      = advance && is_stream;

    // Input register: capture each accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.mode     <= s_tuser;
            item_reg.symbol   <= s_tdata[SYM_W-1:0];
            item_reg.position <= s_tdata[SYM_W +: POS_W];
            item_reg.seq_idx  <= s_tdata[SYM_W+POS_W +: SEQ_W];
            item_reg.last     <= s_tlast;
        end
    end

    shbm_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item        (item_reg),
        .load_en     (load_en),
        .shift_en    (step),
        .pattern_len (plen_reg),
        .match_cnt   (match_cnt)
    );

    shbm_score #(
        .PATTERN_MAX (PATTERN_MAX),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_score (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item        (item_reg),
        .step        (step),
        .match_cnt   (match_cnt),
        .pattern_len (plen_reg),
        .result      (result)
    );

    // Result register: load on a finishing transaction, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emits) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emits) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.final_report;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.best_mask, out_reg.status,
                       out_reg.best_matches, out_reg.done_sequence};

endmodule

`default_nettype wire

/* sv/shbm_match.sv */
`timescale 1ns / 1ps
`default_nettype none

module shbm_match #(
    parameter int PATTERN_MAX = shbm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire shbm_pkg::item_t            item,
    input  wire logic                       load_en,
    input  wire logic                       shift_en,
    input  wire logic [shbm_pkg::CNT_W-1:0] pattern_len,
    output logic      [shbm_pkg::CNT_W-1:0] match_cnt
);
    import shbm_pkg::*;

    logic [SYM_W-1:0]       pattern_reg [PATTERN_MAX];
    logic [SYM_W-1:0]       window_reg  [PATTERN_MAX];
    logic [SYM_W-1:0]       window_next [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] hit;

    // newest symbol enters at slot 0
    always_comb begin
        window_next[0] = item.symbol;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            window_next[k] = window_reg[k-1];
        end
    end

    // pattern slot j lines up with window slot pattern_len-1-j
    always_comb begin : match_bits
        logic [SYM_W-1:0] sel;
        logic             found;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            sel   = '0;
            found = 1'b0;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                if (k + j + 1 == int'(pattern_len)) begin
                    sel   = window_next[k];
                    found = 1'b1;
                end
            end
            hit[j] = found && (sel == pattern_reg[j]);
        end
    end

    assign match_cnt = CNT_W'($countones(hit));

    always_ff @(posedge aclk) begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (load_en && int'(item.position) == k) begin
                pattern_reg[k] <= item.symbol;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                window_reg[k] <= '0;
            end
        end else if (shift_en) begin
            window_reg <= window_next;
        end
    end

endmodule

`default_nettype wire

/* sv/shbm_score.sv */
`timescale 1ns / 1ps
`default_nettype none

module shbm_score #(
    parameter int PATTERN_MAX = shbm_pkg::PATTERN_MAX_DEF,
    parameter int LENGTH_BITS = shbm_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire shbm_pkg::item_t            item,
    input  wire logic                       step,
    input  wire logic [shbm_pkg::CNT_W-1:0] match_cnt,
    input  wire logic [shbm_pkg::CNT_W-1:0] pattern_len,
    output shbm_pkg::result_t               result
);
    import shbm_pkg::*;

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);

    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [CNT_W-1:0]       best_reg, best_next;
    logic [CNT_W-1:0]       seq_best_reg [NUM_SEQ];
    logic [CNT_W-1:0]       seq_best_now [NUM_SEQ];
    logic [CNT_W-1:0]       top;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] first_len_reg;
    status_t                sticky_reg, status_now;
    logic                   full;
    logic                   fin;

    always_comb begin
        fill_next = (int'(fill_reg) < PATTERN_MAX) ? fill_reg + 1'b1 : fill_reg;
        full      = int'(fill_next) >= int'(pattern_len);
        best_next = (full && match_cnt > best_reg) ? match_cnt : best_reg;
        len_next  = (len_reg == '1) ? len_reg : len_reg + 1'b1;
        fin       = (item.seq_idx == SEQ_FINAL);

        // length mismatch takes precedence over shortness; first fault sticks
        status_now = sticky_reg;
        if (item.seq_idx != SEQ_FIRST && len_next != first_len_reg
                && status_now == STATUS_OK) begin
            status_now = STATUS_LEN_DIFF;
        end
        if (len_next < LENGTH_BITS'(pattern_len) && status_now == STATUS_OK) begin
            status_now = STATUS_SHORT;
        end

        top = '0;
        for (int i = 0; i < NUM_SEQ; i++) begin
            seq_best_now[i] = (int'(item.seq_idx) == i) ? best_next : seq_best_reg[i];
            if (seq_best_now[i] > top) begin
                top = seq_best_now[i];
            end
        end

        result.done_sequence = item.seq_idx;
        result.best_matches  = best_next;
        result.status        = status_now;
        result.final_report  = fin;
        for (int i = 0; i < NUM_SEQ; i++) begin
            result.best_mask[i] = fin && top != '0 && status_now == STATUS_OK
                                  && seq_best_now[i] == top;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            best_reg      <= '0;
            len_reg       <= '0;
            first_len_reg <= '0;
            sticky_reg    <= STATUS_OK;
            for (int i = 0; i < NUM_SEQ; i++) begin
                seq_best_reg[i] <= '0;
            end
        end else if (step) begin
            if (item.last) begin
                fill_reg <= '0;
                best_reg <= '0;
                len_reg  <= '0;
                for (int i = 0; i < NUM_SEQ; i++) begin
                    if (int'(item.seq_idx) == i) begin
                        seq_best_reg[i] <= best_next;
                    end
                end
                if (item.seq_idx == SEQ_FIRST) begin
                    first_len_reg <= len_next;
                end
                sticky_reg <= fin ? STATUS_OK : status_now;
            end else begin
                fill_reg <= fill_next;
                best_reg <= best_next;
                len_reg  <= len_next;
            end
        end
    end

endmodule

`default_nettype wire
